// ----- sv/ctbc_pkg.sv -----
// Shared types and constants for the text/binary content classifier.
package ctbc_pkg;

  // Sample limit and control byte ratio
  localparam int SAMPLE_BYTES  = 8192;
  localparam int CONTROL_RATIO = 20;

  // Derived widths
  localparam int COUNT_W     = $clog2(SAMPLE_BYTES + 1);
  localparam int RATIO_W     = (CONTROL_RATIO > 1) ? $clog2(CONTROL_RATIO) : 1;
  localparam int CTRL_W      = 14;
  localparam int LIMIT_W     = (COUNT_W > CTRL_W) ? COUNT_W : CTRL_W;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 14;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_FLOOR = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UTF8_ENABLE   = 1'd1;

  // Verdict causes
  localparam logic [2:0] CAUSE_EMPTY   = 3'd0;
  localparam logic [2:0] CAUSE_MARK    = 3'd1;
  localparam logic [2:0] CAUSE_ZERO    = 3'd2;
  localparam logic [2:0] CAUSE_CONTROL = 3'd3;
  localparam logic [2:0] CAUSE_UTF8    = 3'd4;
  localparam logic [2:0] CAUSE_PLAIN   = 3'd5;

  // Range rules for the next UTF-8 continuation byte
  localparam logic [2:0] CON_ANY     = 3'd0;  // 80..BF
  localparam logic [2:0] CON_AFTER_E0 = 3'd1; // A0..BF
  localparam logic [2:0] CON_AFTER_ED = 3'd2; // 80..9F
  localparam logic [2:0] CON_AFTER_F0 = 3'd3; // 90..BF
  localparam logic [2:0] CON_AFTER_F4 = 3'd4; // 80..8F

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
    logic       empty_sample;
  } sample_t;

  typedef struct packed {
    logic              is_binary;
    logic [2:0]        decision_cause;
    logic [CTRL_W-1:0] control_total;
  } verdict_t;

endpackage

// ----- sv/ctbc_sample_if.sv -----
// Valid/ready channel carrying one sample byte per transaction.
interface ctbc_sample_if;
  import ctbc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/ctbc_verdict_if.sv -----
// Valid/ready channel carrying one verdict per transaction.
interface ctbc_verdict_if;
  import ctbc_pkg::*;

  logic     valid;
  logic     ready;
  verdict_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/text_binary_content_classifier_unit.sv -----
// The final byte passes the input register; its verdict is then registered for output.
// Throughput: one byte per cycle when input is not stalled; all per-byte work sits
// between the input register and the sample state and result registers, so no byte
// waits on another. A waiting verdict stalls input only when the byte in the input
// register ends a sample. Reset (synchronous, active high) clears sample state and
// empties both registers; control_floor and utf8_check_enable return to 1.
module text_binary_content_classifier_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ctbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ctbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  ctbc_sample_if.sink                      sample,
  ctbc_verdict_if.source                   verdict
);
  import ctbc_pkg::*;

  // Configuration
  logic [CTRL_W-1:0] control_floor;
  logic              utf8_check_enable;

  // Input register
  logic    s1_valid;
  sample_t s1;

  // Sample state
  logic [COUNT_W-1:0] byte_count,      byte_count_next;
  logic [31:0]        head_window,     head_window_next;
  logic               zero_seen,       zero_seen_next;
  logic [COUNT_W-1:0] control_count,   control_count_next;
  logic [1:0]         utf8_pending,    utf8_pending_next;
  logic [2:0]         utf8_constraint, utf8_constraint_next;
  logic               utf8_failed,     utf8_failed_next;
  logic [RATIO_W-1:0] ratio_rem,       ratio_rem_next;
  logic [COUNT_W-1:0] ratio_quot,      ratio_quot_next;

  // Per-byte working signals
  logic               keep;
  logic               is_control;
  logic [7:0]         cont_lo;
  logic [7:0]         cont_hi;
  logic               has_mark;
  logic [LIMIT_W-1:0] limit;
  logic [LIMIT_W-1:0] floor_ext;
  logic [LIMIT_W-1:0] quot_ext;
  logic [LIMIT_W-1:0] ctrl_ext;
  logic [7:0]         hb0, hb1, hb2, hb3;
  verdict_t           result;

  // Handshake
  logic s1_produces;
  logic out_free;
  logic s1_fire;

  assign s1_produces  = s1.last_byte | s1.empty_sample;
  assign out_free     = ~verdict.valid | verdict.ready;
  assign s1_fire      = s1_valid & (~s1_produces | out_free);
  assign sample.ready = ~s1_valid | s1_fire;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      control_floor     <= CTRL_W'(1);
      utf8_check_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONTROL_FLOOR: control_floor     <= cfg_data[CTRL_W-1:0];
        REG_UTF8_ENABLE:   utf8_check_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1 <= sample.data;
    end
  end

  // Fold one byte into the sample state
  always_comb begin
    keep       = (byte_count != COUNT_W'(SAMPLE_BYTES));
    is_control = (s1.byte_value < 8'h09) ||
                 ((s1.byte_value > 8'h0D) && (s1.byte_value < 8'h20));

    byte_count_next      = byte_count;
    head_window_next     = head_window;
    zero_seen_next       = zero_seen;
    control_count_next   = control_count;
    ratio_rem_next       = ratio_rem;
    ratio_quot_next      = ratio_quot;
    utf8_pending_next    = utf8_pending;
    utf8_constraint_next = utf8_constraint;
    utf8_failed_next     = utf8_failed;
    cont_lo              = 8'h80;
    cont_hi              = 8'hBF;

    case (utf8_constraint)
      CON_AFTER_E0: cont_lo = 8'hA0;
      CON_AFTER_ED: cont_hi = 8'h9F;
      CON_AFTER_F0: cont_lo = 8'h90;
      CON_AFTER_F4: cont_hi = 8'h8F;
      default: ;
    endcase

    if (keep) begin
      byte_count_next = byte_count + COUNT_W'(1);

      // Place the byte in the head window lane it belongs to
      for (int i = 0; i < 4; i++) begin
        if (byte_count == COUNT_W'(i)) begin
          head_window_next[8*i +: 8] = s1.byte_value;
        end
      end

      if (s1.byte_value == 8'h00) begin
        zero_seen_next = 1'b1;
      end
      if (is_control) begin
        control_count_next = control_count + COUNT_W'(1);
      end

      // Running quotient of the length by the control ratio
      if (ratio_rem == RATIO_W'(CONTROL_RATIO - 1)) begin
        ratio_rem_next  = '0;
        ratio_quot_next = ratio_quot + COUNT_W'(1);
      end else begin
        ratio_rem_next  = ratio_rem + RATIO_W'(1);
      end

      // Strict UTF-8 decoder, sticky on the first failure
      if (!utf8_failed) begin
        if (utf8_pending != 2'd0) begin
          if ((s1.byte_value < cont_lo) || (s1.byte_value > cont_hi)) begin
            utf8_failed_next = 1'b1;
          end else begin
            utf8_pending_next    = utf8_pending - 2'd1;
            utf8_constraint_next = CON_ANY;
          end
        end else if (s1.byte_value >= 8'h80) begin
          if ((s1.byte_value < 8'hC2) || (s1.byte_value > 8'hF4)) begin
            utf8_failed_next = 1'b1;
          end else if (s1.byte_value < 8'hE0) begin
            utf8_pending_next    = 2'd1;
            utf8_constraint_next = CON_ANY;
          end else if (s1.byte_value < 8'hF0) begin
            utf8_pending_next    = 2'd2;
            utf8_constraint_next = (s1.byte_value == 8'hE0) ? CON_AFTER_E0 :
                                   (s1.byte_value == 8'hED) ? CON_AFTER_ED : CON_ANY;
          end else begin
            utf8_pending_next    = 2'd3;
            utf8_constraint_next = (s1.byte_value == 8'hF0) ? CON_AFTER_F0 :
                                   (s1.byte_value == 8'hF4) ? CON_AFTER_F4 : CON_ANY;
          end
        end
      end
    end
  end

  // Work out the verdict from the updated state
  always_comb begin
    hb0 = head_window_next[7:0];
    hb1 = head_window_next[15:8];
    hb2 = head_window_next[23:16];
    hb3 = head_window_next[31:24];

    has_mark =
      ((byte_count_next >= COUNT_W'(3)) && (hb0 == 8'hEF) && (hb1 == 8'hBB) &&
       (hb2 == 8'hBF)) ||
      ((byte_count_next >= COUNT_W'(2)) && (hb0 == 8'hFF) && (hb1 == 8'hFE)) ||
      ((byte_count_next >= COUNT_W'(2)) && (hb0 == 8'hFE) && (hb1 == 8'hFF)) ||
      ((byte_count_next >= COUNT_W'(4)) && (hb0 == 8'h00) && (hb1 == 8'h00) &&
       (hb2 == 8'hFE) && (hb3 == 8'hFF));

    floor_ext = LIMIT_W'(control_floor);
    quot_ext  = LIMIT_W'(ratio_quot_next);
    ctrl_ext  = LIMIT_W'(control_count_next);
    limit     = (floor_ext > quot_ext) ? floor_ext : quot_ext;

    // Saturate the reported total at the field width
    if (ctrl_ext > LIMIT_W'({CTRL_W{1'b1}})) begin
      result.control_total = {CTRL_W{1'b1}};
    end else begin
      result.control_total = ctrl_ext[CTRL_W-1:0];
    end

    if (s1.empty_sample) begin
      result.is_binary      = 1'b0;
      result.decision_cause = CAUSE_EMPTY;
      result.control_total  = '0;
    end else if (has_mark) begin
      result.is_binary      = 1'b0;
      result.decision_cause = CAUSE_MARK;
    end else if (zero_seen_next) begin
      result.is_binary      = 1'b1;
      result.decision_cause = CAUSE_ZERO;
    end else if (ctrl_ext > limit) begin
      result.is_binary      = 1'b1;
      result.decision_cause = CAUSE_CONTROL;
    end else if (utf8_check_enable && utf8_failed_next) begin
      result.is_binary      = 1'b1;
      result.decision_cause = CAUSE_UTF8;
    end else begin
      result.is_binary      = 1'b0;
      result.decision_cause = CAUSE_PLAIN;
    end
  end

  // Advance the sample state; clear it once a verdict is issued
  always_ff @(posedge clk) begin
    if (rst || (s1_fire && s1_produces)) begin
      byte_count      <= '0;
      head_window     <= '0;
      zero_seen       <= 1'b0;
      control_count   <= '0;
      utf8_pending    <= '0;
      utf8_constraint <= CON_ANY;
      utf8_failed     <= 1'b0;
      ratio_rem       <= '0;
      ratio_quot      <= '0;
    end else if (s1_fire) begin
      byte_count      <= byte_count_next;
      head_window     <= head_window_next;
      zero_seen       <= zero_seen_next;
      control_count   <= control_count_next;
      utf8_pending    <= utf8_pending_next;
      utf8_constraint <= utf8_constraint_next;
      utf8_failed     <= utf8_failed_next;
      ratio_rem       <= ratio_rem_next;
      ratio_quot      <= ratio_quot_next;
    end
  end

  // Hold the verdict until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict.valid <= 1'b0;
    end else if (s1_fire && s1_produces) begin
      verdict.valid <= 1'b1;
    end else if (verdict.ready) begin
      verdict.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_produces) begin
      verdict.data <= result;
    end
  end

endmodule

// ----- sv/ctbc_checker.sv -----
// Port-level checks for the content classifier, bound to the top level.
module ctbc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input ctbc_pkg::verdict_t out_data
);
  import ctbc_pkg::*;

  // Hold a stalled verdict unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("verdict changed while stalled");

  // Binary exactly for the zero byte, control and UTF-8 causes
  a_binary_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.is_binary ==
                   ((out_data.decision_cause == CAUSE_ZERO) ||
                    (out_data.decision_cause == CAUSE_CONTROL) ||
                    (out_data.decision_cause == CAUSE_UTF8))))
    else $error("is_binary disagrees with decision_cause");

  // An empty verdict reports no control bytes
  a_empty_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.decision_cause == CAUSE_EMPTY) |->
      (out_data.control_total == '0))
    else $error("empty verdict with nonzero control total");

  // Drop any verdict on reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("verdict valid after reset");

endmodule

bind text_binary_content_classifier_unit ctbc_checker u_ctbc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (verdict.valid),
  .out_ready (verdict.ready),
  .out_data  (verdict.data)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the text/binary content classifier unit.
module tb_top;
  import ctbc_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  // Running scan of the current sample, as the classifier keeps it
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [31:0]        head;
    logic               zero;
    logic [CTRL_W-1:0]  ctrl;
    logic [1:0]         pend;
    logic [2:0]         rule;
    logic               bad;
  } scan_state_t;

  logic clk = 1'b0;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ctbc_sample_if  sample();
  ctbc_verdict_if verdict();

  text_binary_content_classifier_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .verdict   (verdict)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scan_state_t       scan = '0;
  logic [CTRL_W-1:0] floor_cfg = 14'd1;
  logic              utf8_cfg = 1'b1;

  verdict_t   expected_verdicts[$];
  logic [7:0] body[$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_req = 0;

  // Advance the scan by one transaction; return 1 when a verdict is due
  function automatic logic classify_byte(input sample_t item, output verdict_t v);
    logic [7:0]         b;
    logic [7:0]         lo;
    logic [7:0]         hi;
    logic [LIMIT_W-1:0] limit;
    logic               mark;
    b = item.byte_value;
    v = '0;
    if (item.empty_sample) begin
      scan = '0;
      v.decision_cause = CAUSE_EMPTY;
      return 1'b1;
    end
    // Bytes past the sample limit are not examined
    if (scan.count < SAMPLE_BYTES) begin
      if (scan.count < 4) scan.head[8*scan.count +: 8] = b;
      if (b == 8'h00) scan.zero = 1'b1;
      if (b < 8'h09 || (b > 8'h0D && b < 8'h20)) scan.ctrl = scan.ctrl + 1'b1;
      // Strict UTF-8 decode; the first failure sticks
      if (!scan.bad) begin
        if (scan.pend != 2'd0) begin
          lo = 8'h80;
          hi = 8'hBF;
          case (scan.rule)
            CON_AFTER_E0: lo = 8'hA0;
            CON_AFTER_ED: hi = 8'h9F;
            CON_AFTER_F0: lo = 8'h90;
            CON_AFTER_F4: hi = 8'h8F;
            default: ;
          endcase
          if (b < lo || b > hi) begin
            scan.bad = 1'b1;
          end else begin
            scan.pend = scan.pend - 1'b1;
            scan.rule = CON_ANY;
          end
        end else if (b >= 8'h80) begin
          if (b < 8'hC2 || b > 8'hF4) begin
            scan.bad = 1'b1;
          end else if (b < 8'hE0) begin
            scan.pend = 2'd1;
            scan.rule = CON_ANY;
          end else if (b < 8'hF0) begin
            scan.pend = 2'd2;
            scan.rule = (b == 8'hE0) ? CON_AFTER_E0 : (b == 8'hED) ? CON_AFTER_ED : CON_ANY;
          end else begin
            scan.pend = 2'd3;
            scan.rule = (b == 8'hF0) ? CON_AFTER_F0 : (b == 8'hF4) ? CON_AFTER_F4 : CON_ANY;
          end
        end
      end
      scan.count = scan.count + 1'b1;
    end
    if (!item.last_byte) return 1'b0;

    limit = LIMIT_W'(scan.count / CONTROL_RATIO);
    if (floor_cfg > limit) limit = floor_cfg;
    // A mark counts only when all of its bytes arrived
    mark = (scan.count >= 3 && scan.head[23:0] == 24'hBFBBEF) ||
           (scan.count >= 2 && scan.head[15:0] == 16'hFEFF) ||
           (scan.count >= 2 && scan.head[15:0] == 16'hFFFE) ||
           (scan.count >= 4 && scan.head == 32'hFFFE0000);
    v.control_total = scan.ctrl;
    if (mark) begin
      v.decision_cause = CAUSE_MARK;
    end else if (scan.zero) begin
      v.is_binary      = 1'b1;
      v.decision_cause = CAUSE_ZERO;
    end else if (scan.ctrl > limit) begin
      v.is_binary      = 1'b1;
      v.decision_cause = CAUSE_CONTROL;
    end else if (utf8_cfg && scan.bad) begin
      v.is_binary      = 1'b1;
      v.decision_cause = CAUSE_UTF8;
    end else begin
      v.decision_cause = CAUSE_PLAIN;
    end
    scan = '0;
    return 1'b1;
  endfunction

  // Offer one transaction, with random idle cycles ahead of it
  task automatic send_item(input sample_t item);
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.data  <= item;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    if (classify_byte(item, v)) expected_verdicts.push_back(v);
    items_sent++;
  endtask

  // Send the bytes held in body; close marks the final one as last
  task automatic send_body(input logic close);
    sample_t item;
    for (int i = 0; i < body.size(); i++) begin
      item.byte_value   = body[i];
      item.last_byte    = close && (i == body.size() - 1);
      item.empty_sample = 1'b0;
      send_item(item);
    end
  endtask

  task automatic send_empty(input logic [7:0] b, input logic last_flag);
    send_item(sample_t'{b, last_flag, 1'b1});
  endtask

  // Drop valid, wait for every verdict, then let the pipeline drain
  task automatic settle_block();
    sample.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_DATA_W-1:0] floor_value, input logic enable);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CONTROL_FLOOR;
    cfg_data  <= floor_value;
    @(posedge clk);
    cfg_index <= REG_UTF8_ENABLE;
    cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, enable};
    @(posedge clk);
    cfg_we    <= 1'b0;
    floor_cfg = floor_value;
    utf8_cfg  = enable;
  endtask

  // Fill body with one random sample, mostly well formed
  task automatic build_body();
    int len;
    int kind;
    int style;
    logic [7:0] lead;
    body.delete();
    style = $urandom_range(99);
    len = ($urandom_range(9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       body = '{8'hEF, 8'hBB, 8'hBF};
        1:       body = '{8'hFF, 8'hFE};
        2:       body = '{8'hFE, 8'hFF};
        default: body = '{8'h00, 8'h00, 8'hFE, 8'hFF};
      endcase
    end
    while (body.size() < len) begin
      kind = $urandom_range(99);
      if (style >= 85) begin
        body.push_back(8'($urandom_range(255)));
      end else if (kind < 50) begin
        body.push_back(8'($urandom_range(8'h20, 8'h7F)));
      end else if (kind < 58) begin
        body.push_back(8'($urandom_range(8'h09, 8'h0D)));
      end else if (kind < 66) begin
        body.push_back(8'($urandom_range(8'hC2, 8'hDF)));
        body.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 74) begin
        lead = 8'($urandom_range(8'hE0, 8'hEF));
        body.push_back(lead);
        if (lead == 8'hE0)      body.push_back(8'($urandom_range(8'hA0, 8'hBF)));
        else if (lead == 8'hED) body.push_back(8'($urandom_range(8'h80, 8'h9F)));
        else                    body.push_back(8'($urandom_range(8'h80, 8'hBF)));
        body.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 80) begin
        lead = 8'($urandom_range(8'hF0, 8'hF4));
        body.push_back(lead);
        if (lead == 8'hF0)      body.push_back(8'($urandom_range(8'h90, 8'hBF)));
        else if (lead == 8'hF4) body.push_back(8'($urandom_range(8'h80, 8'h8F)));
        else                    body.push_back(8'($urandom_range(8'h80, 8'hBF)));
        body.push_back(8'($urandom_range(8'h80, 8'hBF)));
        body.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (style < 40) begin
        body.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (style < 60) begin
        // Control bytes from both ranges
        if ($urandom_range(1)) body.push_back(8'($urandom_range(8'h01, 8'h08)));
        else                   body.push_back(8'($urandom_range(8'h0E, 8'h1F)));
      end else if (style < 70) begin
        body.push_back((kind < 84) ? 8'h00 : 8'($urandom_range(8'h20, 8'h7E)));
      end else begin
        // Broken UTF-8 pieces
        case ($urandom_range(7))
          0: body.push_back(8'($urandom_range(8'h80, 8'hBF)));
          1: body.push_back(8'($urandom_range(8'hC0, 8'hC1)));
          2: body.push_back(8'($urandom_range(8'hF5, 8'hFF)));
          3: begin
            body.push_back(8'hE0);
            body.push_back(8'($urandom_range(8'h80, 8'h9F)));
          end
          4: begin
            body.push_back(8'hED);
            body.push_back(8'($urandom_range(8'hA0, 8'hBF)));
          end
          5: begin
            body.push_back(8'hF0);
            body.push_back(8'($urandom_range(8'h80, 8'h8F)));
          end
          6: begin
            body.push_back(8'hF4);
            body.push_back(8'($urandom_range(8'h90, 8'hBF)));
          end
          default: begin
            body.push_back(8'($urandom_range(8'hC2, 8'hF4)));
            body.push_back(8'($urandom_range(8'h20, 8'h7E)));
          end
        endcase
      end
    end
    // Leave a sequence open at the sample end now and then
    if ($urandom_range(9) == 0) body.push_back(8'($urandom_range(8'hC2, 8'hF4)));
  endtask

  // Each verdict check
  task automatic test_directed_cases();
    settle_block();
    send_idle_pct = 33;
    recv_idle_pct = 48;
    write_config(14'd1, 1'b1);
    send_empty(8'hFF, 1'b1);
    body = '{8'hEF, 8'hBB, 8'hBF};         send_body(1'b1);
    body = '{8'hFF, 8'hFE};                send_body(1'b1);
    body = '{8'hFE, 8'hFF};                send_body(1'b1);
    body = '{8'h00, 8'h00, 8'hFE, 8'hFF};  send_body(1'b1);
    // Mark cut short by the sample end
    body = '{8'hEF, 8'hBB};                send_body(1'b1);
    body = '{8'h41, 8'h00};                send_body(1'b1);
    body = '{8'h01, 8'h1F};                send_body(1'b1);
    body = '{8'hC0};                       send_body(1'b1);
    // Empty item in the middle of a sample
    body = '{8'h41};                       send_body(1'b0);
    send_empty(8'h00, 1'b0);
    // Sequence left open at the end
    body = '{8'hE4, 8'hB8};                send_body(1'b1);
    body = '{8'h7F};                       send_body(1'b1);
  endtask

  task automatic test_utf8_disable();
    settle_block();
    write_config(14'd1, 1'b0);
    body = '{8'hC0};
    send_body(1'b1);
  endtask

  task automatic test_random_phase(input int n_items, input int send_pct, input int recv_pct,
                                   input logic [CFG_DATA_W-1:0] floor_value,
                                   input logic enable);
    int start;
    int k;
    settle_block();
    write_config(floor_value, enable);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(19) == 0) begin
        send_empty(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        build_body();
        if (body.size() > 1 && $urandom_range(15) == 0) begin
          // Abandon the sample part way with an empty item
          k = $urandom_range(1, body.size() - 1);
          while (body.size() > k) void'(body.pop_back());
          send_body(1'b0);
          send_empty(8'($urandom_range(255)), 1'($urandom_range(1)));
        end else begin
          send_body(1'b1);
        end
      end
    end
  endtask

  // Hold the verdict side off while single-byte samples keep coming
  task automatic test_backpressure();
    settle_block();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= hold_req + 1;
    for (int i = 0; i < 40; i++) begin
      body = '{8'($urandom_range(255))};
      send_body(1'b1);
    end
  endtask

  // Full-length sample at the control threshold, then ignored bytes past the limit
  task automatic test_sample_limit();
    settle_block();
    write_config(14'd1, 1'b1);
    body.delete();
    for (int i = 0; i < SAMPLE_BYTES; i++) begin
      body.push_back((i % 20 == 0 && i < 8180) ? 8'h01 : 8'($urandom_range(8'h61, 8'h7A)));
    end
    body.push_back(8'h00);
    body.push_back(8'h01);
    body.push_back(8'hC0);
    body.push_back(8'h00);
    send_body(1'b1);
  endtask

  // Floor at the sample limit with a sample made of control bytes only
  task automatic test_control_ceiling();
    settle_block();
    write_config(14'd8192, 1'b1);
    body.delete();
    for (int i = 0; i < SAMPLE_BYTES + 2; i++) begin
      if ($urandom_range(1)) body.push_back(8'($urandom_range(8'h01, 8'h08)));
      else                   body.push_back(8'($urandom_range(8'h0E, 8'h1F)));
    end
    send_body(1'b1);
  endtask

  // Verdict side: random ready, with a long hold when one is requested
  initial begin : verdict_sink
    int seen;
    int left;
    seen = 0;
    left = 0;
    verdict.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != seen) begin
        seen = hold_req;
        left = HOLD_CYCLES;
      end
      if (rst) begin
        verdict.ready <= 1'b0;
      end else if (left > 0) begin
        verdict.ready <= 1'b0;
        left--;
      end else begin
        verdict.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each verdict transaction with the oldest prediction
  initial begin : verdict_check
    verdict_t want;
    forever begin
      @(posedge clk);
      if (!rst && verdict.valid && verdict.ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict binary=%0d cause=%0d total=%0d", $time,
                   verdict.data.is_binary, verdict.data.decision_cause,
                   verdict.data.control_total);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict.data !== want) begin
            $display("%0t: expected binary=%0d cause=%0d total=%0d, actual binary=%0d cause=%0d total=%0d",
                     $time, want.is_binary, want.decision_cause, want.control_total,
                     verdict.data.is_binary, verdict.data.decision_cause,
                     verdict.data.control_total);
            mismatches++;
          end
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (sample.valid && sample.ready) || (verdict.valid && verdict.ready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    sample.valid <= 1'b0;
    sample.data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_utf8_disable();
    test_random_phase(450, 33, 48, 14'd1, 1'b1);
    test_random_phase(450, 48, 33, 14'd0, 1'b0);
    test_random_phase(450, 0, 0, 14'($urandom_range(2, 12)), 1'b1);
    test_backpressure();
    test_sample_limit();
    test_control_ceiling();

    settle_block();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
